// ----- hw/rtl/cdm_pkg.sv -----
// Package for the four-channel clock divider/multiplier.
// Holds field widths, opcodes, register indexes and the constant ratio/width tables.
// No dependencies.
package cdm_pkg;

    localparam int CHANNELS   = 4;
    localparam int POSITIONS  = 19;
    localparam int SLOTS      = CHANNELS * POSITIONS;
    localparam int LADDER     = 24;

    localparam int CH_W       = 2;
    localparam int POS_W      = 5;
    localparam int SLOT_W     = 7;
    localparam int OP_W       = 3;
    localparam int VAL_W      = 8;
    localparam int LVL_W      = 4;
    localparam int RATIO_W    = 7;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [RATIO_W-1:0] t_ratio;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PING  = 3'd1;
    localparam logic [OP_W-1:0] OP_RESET = 3'd2;
    localparam logic [OP_W-1:0] OP_RKNOB = 3'd3;
    localparam logic [OP_W-1:0] OP_WKNOB = 3'd4;
    localparam logic [OP_W-1:0] OP_TABLE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RDRIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WDRIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE   = 3'd4;

    localparam logic [15:0] MIN_PW_RST = 16'd100;
    localparam logic [15:0] SLOW_RST   = 16'd160;
    localparam logic [7:0]  RDRIFT_RST = 8'd2;
    localparam logic [7:0]  WDRIFT_RST = 8'd3;
    localparam logic [7:0]  KNOB_RST   = 8'd127;

    localparam logic [7:0] W_FULL = 8'd255;
    localparam logic [7:0] W_TOP  = 8'd250;
    localparam logic [7:0] W_LOW  = 8'd4;

    localparam t_ratio RATIO_MIN  = -7'sd16;
    localparam t_ratio RATIO_NEG1 = -7'sd1;
    localparam t_ratio RATIO_ZERO = 7'sd0;
    localparam t_ratio RATIO_ONE  = 7'sd1;
    localparam t_ratio RATIO_TWO  = 7'sd2;

    localparam t_ratio RATIO_POS [POSITIONS] = '{
        7'sd32, 7'sd16, 7'sd8, 7'sd7, 7'sd6, 7'sd5, 7'sd4, 7'sd3, 7'sd2, 7'sd1,
        -7'sd2, -7'sd3, -7'sd4, -7'sd5, -7'sd6, -7'sd7, -7'sd8, -7'sd12, -7'sd16};

    localparam logic [7:0] DEF_MID [POSITIONS] = '{
        8'd5, 8'd16, 8'd31, 8'd45, 8'd59, 8'd72, 8'd86, 8'd99, 8'd112, 8'd125,
        8'd137, 8'd151, 8'd164, 8'd177, 8'd191, 8'd205, 8'd218, 8'd235, 8'd255};

    localparam logic [7:0] LAD_LIM [LADDER] = '{
        8'd4, 8'd14, 8'd24, 8'd34, 8'd44, 8'd54, 8'd64, 8'd74, 8'd85, 8'd94, 8'd104,
        8'd114, 8'd140, 8'd150, 8'd160, 8'd170, 8'd180, 8'd190, 8'd200, 8'd210,
        8'd220, 8'd230, 8'd240, 8'd250};

    localparam logic [6:0] LAD_BITS [LADDER] = '{
        7'h40, 7'h20, 7'h10, 7'h30, 7'h08, 7'h28, 7'h18, 7'h38, 7'h04, 7'h14, 7'h0C,
        7'h1C, 7'h02, 7'h22, 7'h12, 7'h32, 7'h0A, 7'h2A, 7'h1A, 7'h3A, 7'h06, 7'h16,
        7'h0E, 7'h1E};

    function automatic logic [SLOT_W-1:0] slot_of(logic [CH_W-1:0] ch, logic [POS_W-1:0] p);
        return SLOT_W'(ch) * SLOT_W'(POSITIONS) + SLOT_W'(p);
    endfunction

endpackage

// ----- hw/rtl/cdm_if.sv -----
// Valid/ready channel interfaces for event words in and result words out.
// Depends on cdm_pkg.
interface cdm_in_if;
    import cdm_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] table_index;
    modport source(output valid, opcode, channel, value, table_index, input ready);
    modport sink(input valid, opcode, channel, value, table_index, output ready);
endinterface

interface cdm_out_if;
    import cdm_pkg::*;
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] out_levels;
    t_ratio           ratio;
    logic [OUT_W-1:0] out_period;
    logic [OUT_W-1:0] pulse_ticks;
    modport source(output valid, out_levels, ratio, out_period, pulse_ticks, input ready);
    modport sink(input valid, out_levels, ratio, out_period, pulse_ticks, output ready);
endinterface

// ----- hw/rtl/clock_divider_multiplier_channels.sv -----
// Four-channel clock divider/multiplier, top level with the event sequencer.
// Midpoint table and divisor counters live in two cdm_ram instances.
// Depends on cdm_pkg, cdm_if and cdm_ram.
//
// One event word is handled at a time and gives one result word. Every word
// goes through a dispatch state, the output service pass (S_SV1, S_SV2 and
// S_SV3 for each channel) and a done state that posts the result once the
// result channel can take it. An accepted width knob adds the pulse width
// ladder. An accepted ratio knob adds a read and compare per midpoint walked
// in the table memory, the period step (with the two-step reciprocal multiply
// of divide-by-3/5/6/7/12) and the width ladder; a ping further adds the
// read-modify-write of its 19 divisor counters. Table and counter memories
// need no clearing pass: per-entry and per-row valid bits give the reset
// contents, so words are taken right after reset.
module clock_divider_multiplier_channels #(
    parameter int TIMER_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cdm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cdm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    cdm_in_if.sink                            i_in,
    cdm_out_if.source                         o_res
);
    import cdm_pkg::*;

    localparam int TB     = TIMER_BITS;
    localparam int PROD_W = TIMER_BITS + 6;
    localparam int HB     = (TIMER_BITS + 1) / 2;
    localparam int MG_W   = TIMER_BITS + 2;
    localparam int PR_W   = 2 * TIMER_BITS + 2;
    localparam int QSH    = TIMER_BITS + 3;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [MG_W-1:0] MAG3 = MG_W'(((64'd1 << QSH) + 64'd2) / 64'd3);
    localparam logic [MG_W-1:0] MAG5 = MG_W'(((64'd1 << QSH) + 64'd4) / 64'd5);
    localparam logic [MG_W-1:0] MAG7 = MG_W'(((64'd1 << QSH) + 64'd6) / 64'd7);

    typedef enum logic [3:0] {
        S_IDLE, S_EVT, S_KN_RD, S_KN_CMP, S_PER, S_DIVL, S_HT0, S_HTS,
        S_HTC, S_HTC2, S_CNT_RD, S_CNT_WR, S_SV1, S_SV2, S_SV3, S_DONE
    } t_state;

    t_state r_state;

    logic [OP_W-1:0]  r_op;
    logic [CH_W-1:0]  r_ch;
    logic [VAL_W-1:0] r_val;
    logic [POS_W-1:0] r_idx;

    logic [15:0] r_min_pw, r_slow;
    logic [7:0]  r_rdrift, r_wdrift;
    logic        r_free;

    logic [7:0]    r_rknob    [CHANNELS];
    logic [7:0]    r_wknob    [CHANNELS];
    t_ratio        r_ratio_now[CHANNELS];
    logic [TB-1:0] r_ping     [CHANNELS];
    logic [TB-1:0] r_pnow     [CHANNELS];
    logic [TB-1:0] r_wnow     [CHANNELS];
    logic [TB-1:0] r_roff     [CHANNELS];
    logic [TB-1:0] r_tping    [CHANNELS];
    logic [TB-1:0] r_treset   [CHANNELS];
    logic [TB-1:0] r_tphase   [CHANNELS];
    logic [7:0]    r_pls      [CHANNELS];
    logic [CHANNELS-1:0] r_armed, r_pend, r_seen, r_lvl, r_rowz;
    logic [SLOTS-1:0]    r_mid_vld;

    logic [7:0]        r_knob;
    logic [POS_W-1:0]  r_pos;
    t_ratio            r_ratio, r_old;
    logic [TB-1:0]     r_per, r_acc, r_lo, r_hi, r_quo, r_diff;
    logic [MG_W-1:0]   r_mag;
    logic [PR_W-1:0]   r_prod;
    logic              r_dstep;
    logic [6:0]        r_bits;
    logic [2:0]        r_s;
    logic              r_mvld, r_f_slow;
    logic [CH_W-1:0]   r_svc;
    logic              r_f_pz, r_f_pw, r_f_sr, r_f_pp;

    logic             r_o_valid;
    logic [LVL_W-1:0] r_o_lvl;
    t_ratio           r_o_ratio;
    logic [OUT_W-1:0] r_o_per, r_o_pt;

    logic [SLOT_W-1:0] mid_raddr, mid_waddr, cnt_addr;
    logic              mid_we;
    logic [7:0]        mid_rdata, cnt_rdata, cnt_wdata;
    logic              cnt_we;

    logic [7:0]        mid_now;
    logic [7:0]        w_w;
    logic              lad_hit;
    logic [POS_W-1:0]  lad_k;
    logic [PROD_W-1:0] w_prod;
    logic [TB-1:0]     w_mul;
    logic              div_pow2;
    logic [HB-1:0]     w_mop;
    logic [MG_W+HB-1:0] w_mpart;
    logic [PR_W-1:0]   w_dsum;
    t_ratio            cnt_e;
    logic [7:0]        cnt_cur, cnt_inc;
    logic              cnt_wrap, cnt_hit;
    logic [7:0]        knob_d;
    logic              svc_ping, svc_stop;
    logic [TB-1:0]     svc_lim;
    logic              n_lvl, n_arm, n_pend, n_rea;
    logic [7:0]        n_pls;
    logic [TB-1:0]     n_np;
    logic [TB-1:0]     ht_t;
    logic [CHANNELS-1:0] w_pzm;

    assign mid_raddr = slot_of(r_ch, r_pos);
    assign mid_waddr = slot_of(r_ch, r_idx);
    assign mid_we    = (r_state == S_EVT) && (r_op == OP_TABLE)
                       && (r_idx < POS_W'(POSITIONS));
    assign cnt_addr  = slot_of(r_ch, r_pos);
    assign cnt_we    = (r_state == S_CNT_WR);

    cdm_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (mid_waddr),
        .i_wdata (r_val),
        .i_raddr (mid_raddr),
        .o_rdata (mid_rdata)
    );

    cdm_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_addr),
        .o_rdata (cnt_rdata)
    );

    always_comb begin
        mid_now = r_mvld ? mid_rdata : DEF_MID[r_pos];

        w_w     = W_FULL - r_wknob[r_ch];
        lad_hit = 1'b0;
        lad_k   = '0;
        for (int k = LADDER - 1; k >= 0; k--) begin
            if (w_w < LAD_LIM[k]) begin
                lad_hit = 1'b1;
                lad_k   = POS_W'(k);
            end
        end

        w_prod = PROD_W'(r_ping[r_ch]) * PROD_W'(r_ratio[5:0]);
        w_mul  = (|w_prod[PROD_W-1:TB]) ? TMAX : w_prod[TB-1:0];

        // divide by constant: quotient = (dividend * magic) >> QSH, low half first
        div_pow2 = (r_ratio == -7'sd2) || (r_ratio == -7'sd4) || (r_ratio == -7'sd8);
        w_mop    = r_dstep ? r_quo[HB-1:0] : HB'(r_quo[TB-1:HB]);
        w_mpart  = (MG_W+HB)'(r_mag) * (MG_W+HB)'(w_mop);
        w_dsum   = r_prod + (PR_W'(w_mpart) << HB);

        cnt_e     = RATIO_POS[r_pos];
        cnt_cur   = r_rowz[r_ch] ? 8'd0 : cnt_rdata;
        cnt_inc   = cnt_cur + 8'd1;
        cnt_wrap  = cnt_inc >= {cnt_e[RATIO_W-1], cnt_e};
        cnt_hit   = cnt_wrap && (cnt_e > RATIO_ZERO) && (r_ratio == cnt_e);
        cnt_wdata = cnt_wrap ? 8'd0 : cnt_inc;

        if (r_op == OP_RKNOB) begin
            knob_d = (r_rknob[r_ch] > r_val) ? r_rknob[r_ch] - r_val : r_val - r_rknob[r_ch];
        end else begin
            knob_d = (r_wknob[r_ch] > r_val) ? r_wknob[r_ch] - r_val : r_val - r_wknob[r_ch];
        end

        if (r_f_slow) begin
            ht_t = ((w_w >= W_TOP) || (r_lo > r_hi)) ? r_hi : r_lo;
        end else begin
            ht_t = r_acc;
        end

        svc_ping = (r_op == OP_PING) && (r_svc == r_ch);
        svc_stop = !svc_ping && !r_free
                   && ({1'b0, r_treset[r_svc]} > {r_ping[r_svc], 1'b0});
        svc_lim  = (r_ratio_now[r_svc] > RATIO_ONE) ? r_pnow[r_svc] : r_ping[r_svc];

        n_lvl  = r_lvl[r_svc];
        n_arm  = r_armed[r_svc];
        n_pend = r_pend[r_svc];
        n_pls  = r_pls[r_svc];
        n_rea  = 1'b0;
        n_np   = '0;
        if (r_f_pz) begin
            n_lvl = 1'b0;
        end else begin
            if (r_f_pw) begin
                n_lvl = 1'b0;
            end
            if ((r_f_sr && n_arm) || n_pend) begin
                n_pend = 1'b0;
                n_arm  = 1'b0;
                n_rea  = 1'b1;
                n_np   = '0;
                n_lvl  = 1'b1;
                n_pls  = n_pls - 8'd1;
            end
            if ((r_roff[r_svc] != '0) || ((r_ratio_now[r_svc] < RATIO_ONE)
                && ($signed(n_pls) > $signed({r_ratio_now[r_svc][RATIO_W-1],
                                               r_ratio_now[r_svc]})))) begin
                if (r_f_pp) begin
                    n_rea = 1'b1;
                    n_np  = r_diff;
                    n_lvl = 1'b1;
                    n_pls = n_pls - 8'd1;
                end
            end
        end

        for (int c = 0; c < CHANNELS; c++) begin
            w_pzm[c] = (r_pnow[c] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_TICK;
            r_ch      <= '0;
            r_val     <= '0;
            r_idx     <= '0;
            r_min_pw  <= MIN_PW_RST;
            r_slow    <= SLOW_RST;
            r_rdrift  <= RDRIFT_RST;
            r_wdrift  <= WDRIFT_RST;
            r_free    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_rknob[c]     <= KNOB_RST;
                r_wknob[c]     <= KNOB_RST;
                r_ratio_now[c] <= RATIO_ONE;
                r_ping[c]      <= '0;
                r_pnow[c]      <= '0;
                r_wnow[c]      <= '0;
                r_roff[c]      <= '0;
                r_tping[c]     <= '0;
                r_treset[c]    <= '0;
                r_tphase[c]    <= '0;
                r_pls[c]       <= '0;
            end
            r_armed   <= '1;
            r_pend    <= '0;
            r_seen    <= '0;
            r_lvl     <= '0;
            r_rowz    <= '1;
            r_mid_vld <= '0;
            r_knob    <= '0;
            r_pos     <= '0;
            r_ratio   <= RATIO_ONE;
            r_old     <= RATIO_ONE;
            r_per     <= '0;
            r_acc     <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_quo     <= '0;
            r_diff    <= '0;
            r_mag     <= '0;
            r_prod    <= '0;
            r_dstep   <= 1'b0;
            r_bits    <= '0;
            r_s       <= '0;
            r_mvld    <= 1'b0;
            r_f_slow  <= 1'b0;
            r_svc     <= '0;
            r_f_pz    <= 1'b0;
            r_f_pw    <= 1'b0;
            r_f_sr    <= 1'b0;
            r_f_pp    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_lvl   <= '0;
            r_o_ratio <= RATIO_ZERO;
            r_o_per   <= '0;
            r_o_pt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_PW: r_min_pw <= i_cfg_data;
                    CFG_SLOW:   r_slow   <= i_cfg_data;
                    CFG_RDRIFT: r_rdrift <= i_cfg_data[7:0];
                    CFG_WDRIFT: r_wdrift <= i_cfg_data[7:0];
                    CFG_FREE:   r_free   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_o_valid && o_res.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.opcode;
                        r_ch    <= i_in.channel;
                        r_val   <= i_in.value;
                        r_idx   <= i_in.table_index;
                        r_svc   <= '0;
                        r_state <= S_EVT;
                    end
                end
                S_EVT: begin
                    case (r_op)
                        OP_TICK: begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                if (r_tping[c] != TMAX) r_tping[c] <= r_tping[c] + TB'(1);
                                if (r_treset[c] != TMAX) r_treset[c] <= r_treset[c] + TB'(1);
                                if (r_tphase[c] != TMAX) r_tphase[c] <= r_tphase[c] + TB'(1);
                            end
                            r_state <= S_SV1;
                        end
                        OP_PING: begin
                            r_ping[r_ch]   <= r_tping[r_ch];
                            r_tping[r_ch]  <= '0;
                            r_treset[r_ch] <= '0;
                            r_pls[r_ch]    <= '0;
                            r_knob         <= r_rknob[r_ch];
                            r_pos          <= '0;
                            r_state        <= S_KN_RD;
                        end
                        OP_RESET: begin
                            if (r_val[0]) begin
                                if (!r_seen[r_ch]) begin
                                    r_rowz[r_ch]  <= 1'b1;
                                    r_roff[r_ch]  <= r_treset[r_ch];
                                    r_pend[r_ch]  <= 1'b1;
                                    r_seen[r_ch]  <= 1'b1;
                                    r_armed[r_ch] <= 1'b0;
                                end
                            end else begin
                                r_seen[r_ch] <= 1'b0;
                            end
                            r_state <= S_SV1;
                        end
                        OP_RKNOB: begin
                            if (knob_d >= r_rdrift) begin
                                r_rknob[r_ch] <= r_val;
                                r_knob        <= r_val;
                                r_old         <= r_ratio_now[r_ch];
                                r_pos         <= '0;
                                r_state       <= S_KN_RD;
                            end else begin
                                r_state <= S_SV1;
                            end
                        end
                        OP_WKNOB: begin
                            if (knob_d > r_wdrift) begin
                                r_wknob[r_ch] <= r_val;
                                r_per         <= r_pnow[r_ch];
                                r_state       <= S_HT0;
                            end else begin
                                r_state <= S_SV1;
                            end
                        end
                        OP_TABLE: begin
                            if (mid_we) begin
                                r_mid_vld[mid_waddr] <= 1'b1;
                            end
                            r_state <= S_SV1;
                        end
                        default: r_state <= S_SV1;
                    endcase
                end
                S_KN_RD: begin
                    r_mvld  <= r_mid_vld[mid_raddr];
                    r_state <= S_KN_CMP;
                end
                S_KN_CMP: begin
                    if (r_knob <= mid_now) begin
                        r_ratio             <= RATIO_POS[r_pos];
                        r_ratio_now[r_ch]   <= RATIO_POS[r_pos];
                        r_state             <= S_PER;
                    end else if (r_pos == POS_W'(POSITIONS - 1)) begin
                        r_ratio             <= RATIO_MIN;
                        r_ratio_now[r_ch]   <= RATIO_MIN;
                        r_state             <= S_PER;
                    end else begin
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_KN_RD;
                    end
                end
                S_PER: begin
                    if (r_ratio >= RATIO_TWO) begin
                        r_per   <= w_mul;
                        r_state <= S_HT0;
                    end else if (r_ratio >= RATIO_NEG1) begin
                        r_per   <= r_ping[r_ch];
                        r_state <= S_HT0;
                    end else if (r_ratio == RATIO_MIN) begin
                        r_per   <= (r_ping[r_ch] >> 4) + TB'(1);
                        r_state <= S_HT0;
                    end else begin
                        r_dstep <= 1'b1;
                        r_state <= div_pow2 ? S_HT0 : S_DIVL;
                        case (r_ratio)
                            -7'sd2:  r_per <= r_ping[r_ch] >> 1;
                            -7'sd4:  r_per <= r_ping[r_ch] >> 2;
                            -7'sd8:  r_per <= r_ping[r_ch] >> 3;
                            -7'sd3: begin
                                r_quo <= r_ping[r_ch];
                                r_mag <= MAG3;
                            end
                            -7'sd6: begin
                                r_quo <= r_ping[r_ch] >> 1;
                                r_mag <= MAG3;
                            end
                            -7'sd12: begin
                                r_quo <= r_ping[r_ch] >> 2;
                                r_mag <= MAG3;
                            end
                            -7'sd5: begin
                                r_quo <= r_ping[r_ch];
                                r_mag <= MAG5;
                            end
                            default: begin
                                r_quo <= r_ping[r_ch];
                                r_mag <= MAG7;
                            end
                        endcase
                    end
                end
                S_DIVL: begin
                    if (r_dstep) begin
                        r_prod  <= PR_W'(w_mpart);
                        r_dstep <= 1'b0;
                    end else begin
                        r_per   <= TB'(w_dsum[PR_W-1:QSH]);
                        r_state <= S_HT0;
                    end
                end
                S_HT0: begin
                    r_pnow[r_ch] <= r_per;
                    if (lad_hit) begin
                        r_acc   <= '0;
                        r_bits  <= LAD_BITS[lad_k];
                        r_s     <= 3'd1;
                        r_state <= S_HTS;
                    end else begin
                        r_acc   <= r_per - (r_per >> 5);
                        r_state <= S_HTC;
                    end
                end
                S_HTS: begin
                    if (r_bits[r_s]) begin
                        r_acc <= r_acc + (r_per >> r_s);
                    end
                    if (r_s == 3'd6) begin
                        r_state <= S_HTC;
                    end else begin
                        r_s <= r_s + 3'd1;
                    end
                end
                S_HTC: begin
                    r_f_slow <= r_per > TB'(r_slow);
                    r_lo     <= ((w_w < W_LOW) || (r_acc < TB'(r_min_pw))) ? TB'(r_min_pw) : r_acc;
                    r_hi     <= (r_per > TB'(r_min_pw)) ? r_per - TB'(r_min_pw) : '0;
                    r_state  <= S_HTC2;
                end
                S_HTC2: begin
                    r_wnow[r_ch] <= ht_t;
                    if (r_op == OP_PING) begin
                        if (r_ratio <= RATIO_ONE) begin
                            r_armed[r_ch] <= 1'b1;
                            if (r_roff[r_ch] == '0) r_tphase[r_ch] <= '0;
                        end
                        r_pos   <= '0;
                        r_state <= S_CNT_RD;
                    end else begin
                        if ((r_op == OP_RKNOB) && (r_ratio == RATIO_MIN)
                            && (r_old != RATIO_MIN)) begin
                            r_roff[r_ch] <= '0;
                        end
                        r_state <= S_SV1;
                    end
                end
                S_CNT_RD: begin
                    r_state <= S_CNT_WR;
                end
                S_CNT_WR: begin
                    if (cnt_hit) begin
                        r_armed[r_ch] <= 1'b1;
                        if (r_roff[r_ch] == '0) r_tphase[r_ch] <= '0;
                    end
                    if (r_pos == POS_W'(POSITIONS - 1)) begin
                        r_rowz[r_ch] <= 1'b0;
                        r_state      <= S_SV1;
                    end else begin
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_CNT_RD;
                    end
                end
                S_SV1: begin
                    if (svc_stop) begin
                        r_pnow[r_svc] <= '0;
                        r_roff[r_svc] <= '0;
                        r_rowz[r_svc] <= 1'b1;
                    end else if ((r_roff[r_svc] != '0) && (r_roff[r_svc] > svc_lim)) begin
                        r_roff[r_svc] <= '0;
                    end
                    r_state <= S_SV2;
                end
                S_SV2: begin
                    r_f_pz  <= (r_pnow[r_svc] == '0);
                    r_f_pw  <= r_tphase[r_svc] >= r_wnow[r_svc];
                    r_f_sr  <= r_treset[r_svc] >= r_roff[r_svc];
                    r_f_pp  <= r_tphase[r_svc] >= r_pnow[r_svc];
                    r_diff  <= r_tphase[r_svc] - r_pnow[r_svc];
                    r_state <= S_SV3;
                end
                S_SV3: begin
                    r_lvl[r_svc]   <= n_lvl;
                    r_armed[r_svc] <= n_arm;
                    r_pend[r_svc]  <= n_pend;
                    r_pls[r_svc]   <= n_pls;
                    if (n_rea) r_tphase[r_svc] <= n_np;
                    if (r_svc == CH_W'(CHANNELS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_svc   <= r_svc + CH_W'(1);
                        r_state <= S_SV1;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_lvl   <= r_lvl;
                        r_o_ratio <= r_ratio_now[r_ch];
                        r_o_per   <= OUT_W'(r_pnow[r_ch]);
                        r_o_pt    <= OUT_W'(r_wnow[r_ch]);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_o_valid;
    assign o_res.out_levels  = r_o_lvl;
    assign o_res.ratio       = r_o_ratio;
    assign o_res.out_period  = r_o_per;
    assign o_res.pulse_ticks = r_o_pt;

    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("event word accepted while previous word still in flight");

    a_stopped_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_lvl & w_pzm) == '0))
        else $error("stopped channel drives a high output level");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result word posted outside the done state");
endmodule

// ----- hw/rtl/cdm_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module cdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 76
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sim/cdm_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the clock divider/multiplier: watches the config port and both word
// channels, predicts each result word from the event words and compares them.
// Depends on cdm_pkg and cdm_if.
module cdm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cdm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cdm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cdm_in_if                              ev_w,
    cdm_out_if                             res_w,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import cdm_pkg::*;

    typedef struct packed {
        logic [LVL_W-1:0] levels;
        t_ratio           ratio;
        logic [OUT_W-1:0] period;
        logic [OUT_W-1:0] pulse;
    } t_result;

    localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF;

    t_result     result_q[$];
    int          errors;
    int          checked;

    logic [31:0] min_pw, slow_per;
    logic [7:0]  rdrift, wdrift;
    logic        free;

    logic [7:0]  mid_tab [SLOTS];
    logic [7:0]  div_cnt [SLOTS];
    logic [7:0]  rknob [CHANNELS];
    logic [7:0]  wknob [CHANNELS];
    t_ratio      ratio_cur [CHANNELS];
    logic [31:0] ping_per [CHANNELS];
    logic [31:0] per_cur [CHANNELS];
    logic [31:0] width_cur [CHANNELS];
    logic [31:0] rst_off [CHANNELS];
    logic [31:0] t_ping [CHANNELS];
    logic [31:0] t_rst [CHANNELS];
    logic [31:0] t_phase [CHANNELS];
    logic [7:0]  pulses [CHANNELS];
    logic        armed [CHANNELS];
    logic        pend [CHANNELS];
    logic        seen [CHANNELS];
    logic        lvl [CHANNELS];

    function automatic t_ratio lookup_ratio(int ch, logic [7:0] k);
        for (int p = 0; p < POSITIONS; p++) begin
            if (k <= mid_tab[ch * POSITIONS + p]) return RATIO_POS[p];
        end
        return RATIO_MIN;
    endfunction

    function automatic logic [31:0] scaled_period(t_ratio r, logic [31:0] p);
        logic [63:0] v;
        if (r >= RATIO_TWO) v = 64'(p) * 64'(r);
        else if (r >= RATIO_NEG1) v = 64'(p);
        else if (r == RATIO_MIN) v = 64'(p >> 4) + 64'd1;
        else v = 64'(p / 32'(-r));
        return (v > 64'(TIMER_MAX)) ? TIMER_MAX : v[31:0];
    endfunction

    function automatic logic [31:0] high_ticks(logic [7:0] knob, logic [31:0] per);
        logic [7:0]  w;
        logic [31:0] t, hi;
        int          k;
        w = W_FULL - knob;
        t = 0;
        k = LADDER;
        for (int i = LADDER - 1; i >= 0; i--) begin
            if (w < LAD_LIM[i]) k = i;
        end
        if (k < LADDER) begin
            for (int s = 1; s <= 6; s++) begin
                if (LAD_BITS[k][s]) t = t + (per >> s);
            end
        end else begin
            t = per - (per >> 5);
        end
        if (per > slow_per) begin
            if (w < W_LOW || t < min_pw) t = min_pw;
            hi = (per > min_pw) ? per - min_pw : 32'd0;
            if (w >= W_TOP || t > hi) t = hi;
        end
        return t;
    endfunction

    task automatic clear_counters(int ch);
        for (int p = 0; p < POSITIONS; p++) div_cnt[ch * POSITIONS + p] = 8'd0;
    endtask

    task automatic ping_event(int ch);
        t_ratio     r, e;
        logic [7:0] eu;
        int         s;
        ping_per[ch] = t_ping[ch];
        t_ping[ch] = 0;
        t_rst[ch] = 0;
        r = lookup_ratio(ch, rknob[ch]);
        ratio_cur[ch] = r;
        per_cur[ch] = scaled_period(r, ping_per[ch]);
        width_cur[ch] = high_ticks(wknob[ch], per_cur[ch]);
        pulses[ch] = 8'd0;
        if (r <= RATIO_ONE) begin
            armed[ch] = 1'b1;
            if (rst_off[ch] == 0) t_phase[ch] = 0;
        end
        for (int p = 0; p < POSITIONS; p++) begin
            s = ch * POSITIONS + p;
            e = RATIO_POS[p];
            eu = 8'(e);
            div_cnt[s] = div_cnt[s] + 8'd1;
            if (div_cnt[s] >= eu) begin
                if (e > RATIO_ZERO && r == e) begin
                    armed[ch] = 1'b1;
                    if (rst_off[ch] == 0) t_phase[ch] = 0;
                end
                div_cnt[s] = 8'd0;
            end
        end
    endtask

    task automatic service_pass(int ch, bit pinged);
        logic              realign;
        logic [31:0]       np, lim;
        logic signed [7:0] pc;
        realign = 1'b0;
        np = 0;
        if (!pinged && !free && (33'(t_rst[ch]) > (33'(ping_per[ch]) << 1))) begin
            per_cur[ch] = 0;
            rst_off[ch] = 0;
            clear_counters(ch);
        end
        if (rst_off[ch] > 0) begin
            lim = (ratio_cur[ch] > RATIO_ONE) ? per_cur[ch] : ping_per[ch];
            if (rst_off[ch] > lim) rst_off[ch] = 0;
        end
        if (per_cur[ch] == 0) begin
            lvl[ch] = 1'b0;
            return;
        end
        if (t_phase[ch] >= width_cur[ch]) lvl[ch] = 1'b0;
        if ((t_rst[ch] >= rst_off[ch] && armed[ch]) || pend[ch]) begin
            pend[ch] = 1'b0;
            armed[ch] = 1'b0;
            realign = 1'b1;
            np = 0;
            lvl[ch] = 1'b1;
            pulses[ch] = pulses[ch] - 8'd1;
        end
        pc = pulses[ch];
        if (rst_off[ch] != 0 || (ratio_cur[ch] < RATIO_ONE && pc > ratio_cur[ch])) begin
            if (t_phase[ch] >= per_cur[ch]) begin
                realign = 1'b1;
                np = t_phase[ch] - per_cur[ch];
                lvl[ch] = 1'b1;
                pulses[ch] = pulses[ch] - 8'd1;
            end
        end
        if (realign) t_phase[ch] = np;
    endtask

    task automatic apply_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] chn,
                              input logic [7:0] val, input logic [POS_W-1:0] idx,
                              output t_result res);
        int         ch;
        logic [7:0] d;
        t_ratio     old;
        ch = int'(chn);
        case (op)
            OP_TICK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (t_ping[c] != TIMER_MAX) t_ping[c]++;
                    if (t_rst[c] != TIMER_MAX) t_rst[c]++;
                    if (t_phase[c] != TIMER_MAX) t_phase[c]++;
                end
            end
            OP_PING: ping_event(ch);
            OP_RESET: begin
                if (val[0]) begin
                    if (!seen[ch]) begin
                        clear_counters(ch);
                        rst_off[ch] = t_rst[ch];
                        pend[ch] = 1'b1;
                        seen[ch] = 1'b1;
                        armed[ch] = 1'b0;
                    end
                end else begin
                    seen[ch] = 1'b0;
                end
            end
            OP_RKNOB: begin
                d = (rknob[ch] > val) ? rknob[ch] - val : val - rknob[ch];
                if (d >= rdrift) begin
                    old = ratio_cur[ch];
                    rknob[ch] = val;
                    ratio_cur[ch] = lookup_ratio(ch, val);
                    per_cur[ch] = scaled_period(ratio_cur[ch], ping_per[ch]);
                    width_cur[ch] = high_ticks(wknob[ch], per_cur[ch]);
                    if (ratio_cur[ch] == RATIO_MIN && old != RATIO_MIN) rst_off[ch] = 0;
                end
            end
            OP_WKNOB: begin
                d = (wknob[ch] > val) ? wknob[ch] - val : val - wknob[ch];
                if (d > wdrift) begin
                    wknob[ch] = val;
                    width_cur[ch] = high_ticks(val, per_cur[ch]);
                end
            end
            OP_TABLE: begin
                if (idx < POSITIONS) mid_tab[ch * POSITIONS + int'(idx)] = val;
            end
            default: ;
        endcase
        for (int c = 0; c < CHANNELS; c++) service_pass(c, op == OP_PING && c == ch);
        for (int c = 0; c < LVL_W; c++) res.levels[c] = lvl[c];
        res.ratio = ratio_cur[ch];
        res.period = per_cur[ch];
        res.pulse = width_cur[ch];
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH word %0d %s: got %0h, expected %0h", checked, what, got, want);
        errors++;
    endtask

    task automatic reset_model();
        min_pw = 32'(MIN_PW_RST);
        slow_per = 32'(SLOW_RST);
        rdrift = RDRIFT_RST;
        wdrift = WDRIFT_RST;
        free = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            mid_tab[s] = DEF_MID[s % POSITIONS];
            div_cnt[s] = 8'd0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            rknob[c] = KNOB_RST;
            wknob[c] = KNOB_RST;
            ratio_cur[c] = RATIO_ONE;
            ping_per[c] = 0;
            per_cur[c] = 0;
            width_cur[c] = 0;
            rst_off[c] = 0;
            t_ping[c] = 0;
            t_rst[c] = 0;
            t_phase[c] = 0;
            pulses[c] = 8'd0;
            armed[c] = 1'b1;
            pend[c] = 1'b0;
            seen[c] = 1'b0;
            lvl[c] = 1'b0;
        end
        result_q.delete();
    endtask

    initial begin
        errors = 0;
        checked = 0;
        reset_model();
    end

    always @(posedge i_clk) begin
        t_result r, want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_PW: min_pw = 32'(i_cfg_data);
                    CFG_SLOW:   slow_per = 32'(i_cfg_data);
                    CFG_RDRIFT: rdrift = i_cfg_data[7:0];
                    CFG_WDRIFT: wdrift = i_cfg_data[7:0];
                    CFG_FREE:   free = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (ev_w.valid && ev_w.ready) begin
                apply_word(ev_w.opcode, ev_w.channel, ev_w.value, ev_w.table_index, r);
                result_q.push_back(r);
            end
            if (res_w.valid && res_w.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(res_w.out_period), 64'd0);
                end else begin
                    want = result_q.pop_front();
                    if (res_w.out_levels !== want.levels)
                        report_mismatch("out_levels", 64'(res_w.out_levels), 64'(want.levels));
                    if (res_w.ratio !== want.ratio)
                        report_mismatch("ratio", 64'(unsigned'(res_w.ratio)),
                                        64'(unsigned'(want.ratio)));
                    if (res_w.out_period !== want.period)
                        report_mismatch("out_period", 64'(res_w.out_period), 64'(want.period));
                    if (res_w.pulse_ticks !== want.pulse)
                        report_mismatch("pulse_ticks", 64'(res_w.pulse_ticks), 64'(want.pulse));
                end
                checked++;
            end
        end
        o_errors <= errors;
        o_pending <= result_q.size();
        o_checked <= checked;
    end

endmodule

// ----- sim/clock_divider_multiplier_channels_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the clock divider/multiplier: clock, reset, event stimulus,
// config phases, result back-pressure, watchdog and verdict.
// Depends on cdm_pkg, cdm_if, cdm_checker and the block itself.
module clock_divider_multiplier_channels_tb;
    import cdm_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors, pending, checked;
    int                    words_sent, settings_used, stall_cycles;
    bit                    no_idle, hold_req;
    int                    ping_w;

    cdm_in_if  ev_w();
    cdm_out_if res_w();

    clock_divider_multiplier_channels DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (ev_w),
        .o_res     (res_w)
    );

    cdm_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .ev_w      (ev_w),
        .res_w     (res_w),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        ev_w.valid = 1'b0;
        ev_w.opcode = OP_TICK;
        ev_w.channel = '0;
        ev_w.value = '0;
        ev_w.table_index = '0;
        res_w.ready = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        static int  hold_left = 0;
        static int  gap_left = 0;
        static bit  hold_taken = 0;
        if (!i_rst_n) begin
            res_w.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_w.ready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1;
            hold_left = LONG_HOLD;
            res_w.ready <= 1'b0;
        end else if (no_idle) begin
            res_w.ready <= 1'b1;
        end else if (gap_left > 0) begin
            res_w.ready <= 1'b0;
            gap_left--;
        end else begin
            res_w.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 9);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (ev_w.valid && ev_w.ready) || (res_w.valid && res_w.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                        input logic [VAL_W-1:0] val, input logic [POS_W-1:0] idx);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            ev_w.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        ev_w.valid <= 1'b1;
        ev_w.opcode <= op;
        ev_w.channel <= ch;
        ev_w.value <= val;
        ev_w.table_index <= idx;
        @(posedge i_clk);
        while (!ev_w.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain(input int extra);
        ev_w.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int mpw, input int slow, input int rd, input int wd,
                            input int fr);
        cfg_write(CFG_MIN_PW, mpw);
        cfg_write(CFG_SLOW, slow);
        cfg_write(CFG_RDRIFT, rd);
        cfg_write(CFG_WDRIFT, wd);
        cfg_write(CFG_FREE, fr);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic random_word();
        int               r;
        logic [CH_W-1:0]  ch;
        ch = CH_W'($urandom_range(0, CHANNELS - 1));
        r = $urandom_range(0, 99);
        if (r < 60)
            send(OP_TICK, ch, VAL_W'($urandom), POS_W'($urandom));
        else if (r < 60 + ping_w)
            send(OP_PING, ch, VAL_W'($urandom), POS_W'($urandom));
        else if (r < 82)
            send(OP_RKNOB, ch, VAL_W'($urandom), POS_W'($urandom));
        else if (r < 88)
            send(OP_WKNOB, ch, VAL_W'($urandom), POS_W'($urandom));
        else if (r < 94)
            send(OP_RESET, ch, VAL_W'($urandom), POS_W'($urandom));
        else if (r < 97)
            send(OP_TABLE, ch, VAL_W'($urandom), POS_W'($urandom_range(0, 31)));
        else
            send(OP_W'($urandom_range(6, 7)), ch, VAL_W'($urandom), POS_W'($urandom));
    endtask

    initial begin
        words_sent = 0;
        settings_used = 0;
        stall_cycles = 0;
        no_idle = 0;
        hold_req = 0;
        ping_w = 15;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: knob extremes, pings, resets, table edges, unknown opcodes
        send(OP_WKNOB, 2'd0, 8'd0, 5'd0);
        send(OP_PING, 2'd0, 8'd0, 5'd0);
        repeat (3) send(OP_TICK, 2'd0, 8'd0, 5'd0);
        send(OP_PING, 2'd0, 8'd0, 5'd0);
        send(OP_RKNOB, 2'd0, 8'd0, 5'd0);
        send(OP_TICK, 2'd0, 8'd0, 5'd0);
        send(OP_RKNOB, 2'd0, 8'd255, 5'd0);
        send(OP_PING, 2'd3, 8'd0, 5'd0);
        send(OP_TICK, 2'd3, 8'd0, 5'd0);
        send(OP_PING, 2'd3, 8'd0, 5'd0);
        send(OP_RESET, 2'd3, 8'd1, 5'd0);
        send(OP_RESET, 2'd3, 8'd255, 5'd0);
        send(OP_RESET, 2'd3, 8'd0, 5'd0);
        send(OP_WKNOB, 2'd3, 8'd255, 5'd0);
        send(OP_TABLE, 2'd1, 8'd255, 5'd18);
        send(OP_TABLE, 2'd1, 8'd0, 5'd0);
        send(OP_TABLE, 2'd2, 8'd9, 5'd31);
        send(3'd6, 2'd2, 8'd0, 5'd0);
        send(3'd7, 2'd1, 8'd255, 5'd31);
        repeat (4) send(OP_TICK, 2'd0, 8'd0, 5'd0);
        drain(SETTLE);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(100, 160, 2, 3, 0);
                1: set_regs(0, 0, 0, 0, 1);
                2: set_regs(65535, 65535, 255, 255, 0);
                3: set_regs(20, 40, 1, 1, 0);
                4: set_regs($urandom_range(0, 300), $urandom_range(0, 400),
                            $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 1));
                default: set_regs(100, 160, 2, 3, 1);
            endcase
            ping_w = (ph % 2 == 1) ? 4 : 15;
            no_idle = (ph == 5);
            for (int n = 0; n < 315; n++) begin
                if (ph == 2 && n == 100) hold_req = 1;
                if (ph == 1 && n == 150) drain(0);
                random_word();
            end
            drain(SETTLE);
        end

        $display("Sent %0d event words under %0d register settings; %0d results checked",
                 words_sent, settings_used, checked);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- clock_divider_multiplier_channels.f -----
hw/rtl/cdm_pkg.sv
hw/rtl/cdm_if.sv
hw/rtl/cdm_ram.sv
hw/rtl/clock_divider_multiplier_channels.sv
sim/cdm_checker.sv
sim/clock_divider_multiplier_channels_tb.sv
